@@ rtl/mgc_pkg.sv @@
package mgc_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OUT_W    = 21;
  localparam int unsigned MAG_W    = 20;
  localparam int unsigned SUM_W    = 54;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W;
  localparam int unsigned GAIN_SHIFT = 14;
  localparam int unsigned SQ_W     = 2 * MAG_W;

  localparam logic [MAG_W-1:0]  ONE_Q19    = MAG_W'(524288);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

  // Divide and square root step counts
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS = MAG_W;
  localparam int unsigned STEP_W     = 6;

  // Register indexes on the APB port
  localparam logic REG_MASTER_GAIN = 1'b0;
  localparam logic REG_MUTE        = 1'b1;

  // One word handed from the front to the back through the queue
  typedef struct packed {
    logic signed [OUT_W-1:0] sample;
    logic                    closes;
    logic [MAG_W-1:0]        peak;
    logic [SUM_W-1:0]        sum;
    logic [CNT_W-1:0]        count;
  } mgc_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } mgc_state_t;

endpackage

@@ rtl/mgc_in_if.sv @@
interface mgc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mixed_sample;
  logic               last_in_block;

  modport source (output valid, output mixed_sample, output last_in_block, input ready);
  modport sink   (input valid, input mixed_sample, input last_in_block, output ready);
endinterface

@@ rtl/mgc_out_if.sv @@
interface mgc_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] out_sample;
  logic               meter_valid;
  logic [19:0]        block_peak;
  logic [19:0]        block_rms;

  modport source (output valid, output out_sample, output meter_valid, output block_peak,
                  output block_rms, input ready);
  modport sink   (input valid, input out_sample, input meter_valid, input block_peak,
                  input block_rms, output ready);
endinterface

@@ rtl/master_gain_clip_meter.sv @@
// Channel   Dir   Words carried
// -------   ---   ------------------------------------------------------
// in_ch     in    mixed_sample (Q4.19), last_in_block
// out_ch    out   out_sample (Q1.19), meter_valid, block_peak, block_rms
// apb       in    reg 0 master_gain (Q2.14) at 0x0, reg 1 mute at 0x4
//
// Ordinary samples stream at one word per cycle while neither side stalls, through
// the gain pipeline stages into the queue and then through the output register.
// A word that closes a block holds the back through 54 divide steps for the mean
// square and 20 root steps, with the idle and done states around them;
// the queue keeps the front running meanwhile until it fills.
// rst is synchronous and clears all control state; master_gain returns to unity.
// Either side may stall at any time; the queue and output register part them.
module master_gain_clip_meter #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 32768,
  parameter int unsigned QUEUE_DEPTH       = 4
) (
  input  logic        clk,
  input  logic        rst,
  mgc_in_if.sink      in_ch,
  mgc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mgc_pkg::*;

  logic [GAIN_W-1:0] master_gain;
  logic              mute;
  logic              cfg_wr;
  logic              reg_sel;

  logic              push;
  mgc_entry_t        push_entry;
  logic              q_full;
  logic              pop;
  mgc_entry_t        head;
  logic              q_empty;

  // Register file: word index is the address over four
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain <= GAIN_RESET;
      mute        <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MASTER_GAIN: master_gain <= pwdata[GAIN_W-1:0];
        REG_MUTE:        mute        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MASTER_GAIN: prdata = {{(32-GAIN_W){1'b0}}, master_gain};
      REG_MUTE:        prdata = {31'b0, mute};
      default:         prdata = '0;
    endcase
  end

  // Front: gain, clamp, block accumulate
  mgc_front #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .mixed_sample (in_ch.mixed_sample),
    .last_in_block(in_ch.last_in_block),
    .master_gain  (master_gain),
    .mute         (mute),
    .push         (push),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  // Hold words while the back works on a block end
  mgc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Back: pass samples, or divide and root on a block end
  mgc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.out_sample),
    .meter_valid(out_ch.meter_valid),
    .block_peak (out_ch.block_peak),
    .block_rms  (out_ch.block_rms)
  );

  assert property (@(posedge clk) disable iff (rst) cfg_wr && reg_sel == REG_MUTE
                   |=> mute == $past(pwdata[0]))
    else $error("mute write lost");
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("front pushed into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("back popped empty queue");

endmodule

@@ rtl/mgc_front.sv @@
module mgc_front #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 32768
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [23:0]          mixed_sample,
  input  logic                        last_in_block,
  input  logic [15:0]                 master_gain,
  input  logic                        mute,
  output logic                        push,
  output mgc_pkg::mgc_entry_t         push_entry,
  input  logic                        q_full
);
  import mgc_pkg::*;

  logic                    s1_valid;
  logic [PROD_W-1:0]       s1_prod;
  logic                    s1_neg;
  logic                    s1_last;
  logic                    s2_valid;
  logic [MAG_W-1:0]        s2_amag;
  logic signed [OUT_W-1:0] s2_sample;
  logic [SQ_W-1:0]         s2_sq;
  logic                    s2_last;

  logic [MAG_W-1:0]        peak;
  logic [SUM_W-1:0]        sum;
  logic [CNT_W-1:0]        count;

  logic                    in_neg;
  logic [SAMPLE_W-1:0]     in_mag;
  logic [PROD_W-1:0]       in_prod;
  logic [PROD_W:0]         q_sum;
  logic [PROD_W-GAIN_SHIFT:0] q;
  logic [MAG_W-1:0]        amag;
  logic signed [OUT_W-1:0] sample_c;
  logic                    s1_adv;
  logic                    s2_take;
  logic [MAG_W-1:0]        peak_next;
  logic [SUM_W-1:0]        sum_next;
  logic [CNT_W-1:0]        count_next;
  logic                    closes;

  // Stage 1: magnitude times gain
  assign in_neg  = mixed_sample[SAMPLE_W-1];
  assign in_mag  = in_neg ? (SAMPLE_W'(0) - SAMPLE_W'(mixed_sample)) : SAMPLE_W'(mixed_sample);
  assign in_prod = {{GAIN_W{1'b0}}, in_mag} * {{SAMPLE_W{1'b0}}, master_gain};

  // Stage 2: floor shift, clamp, mute, sign back on
  assign q_sum = {1'b0, s1_prod} + (s1_neg ? (PROD_W+1)'((1 << GAIN_SHIFT) - 1)
                                             : (PROD_W+1)'(0));
  assign q     = q_sum[PROD_W:GAIN_SHIFT];
  always_comb begin
    if (mute) begin
      amag = '0;
    end else if (q > (PROD_W-GAIN_SHIFT+1)'(ONE_Q19)) begin
      amag = ONE_Q19;
    end else begin
      amag = q[MAG_W-1:0];
    end
  end
  assign sample_c = (s1_neg && amag != '0) ? (OUT_W'(0) - OUT_W'(amag)) : OUT_W'(amag);

  assign push     = s2_valid && !q_full;
  assign s2_take  = !s2_valid || push;
  assign s1_adv   = s1_valid && s2_take;
  assign in_ready = !s1_valid || s2_take;

  // Block accumulators, updated as a word leaves for the queue
  assign peak_next  = (s2_amag > peak) ? s2_amag : peak;
  assign sum_next   = sum + SUM_W'(s2_sq);
  assign count_next = count + CNT_W'(1);
  assign closes     = s2_last || ({1'b0, count_next} >= (CNT_W+1)'(MAX_BLOCK_SAMPLES));

  always_comb begin
    push_entry.sample = s2_sample;
    push_entry.closes = closes;
    push_entry.peak   = peak_next;
    push_entry.sum    = sum_next;
    push_entry.count  = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      peak     <= '0;
      sum      <= '0;
      count    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
      if (push) begin
        if (closes) begin
          peak  <= '0;
          sum   <= '0;
          count <= '0;
        end else begin
          peak  <= peak_next;
          sum   <= sum_next;
          count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_prod <= in_prod;
      s1_neg  <= in_neg;
      s1_last <= last_in_block;
    end
    if (s1_adv) begin
      s2_amag   <= amag;
      s2_sample <= sample_c;
      s2_sq     <= {{MAG_W{1'b0}}, amag} * {{MAG_W{1'b0}}, amag};
      s2_last   <= s1_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push && closes |=> count == '0)
    else $error("accumulators not cleared after block end");
  assert property (@(posedge clk) disable iff (rst)
                   s1_valid && !s2_take |=> s1_valid && $stable(s1_prod))
    else $error("stage 1 lost while stalled");
  assert property (@(posedge clk) disable iff (rst) s2_valid |-> s2_amag <= ONE_Q19)
    else $error("clamp exceeded");

endmodule

@@ rtl/mgc_queue.sv @@
module mgc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mgc_pkg::mgc_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output mgc_pkg::mgc_entry_t head,
  output logic                empty
);
  import mgc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  mgc_entry_t        mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full  = fill == FILL_W'(DEPTH);
  assign empty = fill == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) fill <= FILL_W'(DEPTH))
    else $error("queue fill out of range");

endmodule

@@ rtl/mgc_back.sv @@
module mgc_back (
  input  logic                clk,
  input  logic                rst,
  input  mgc_pkg::mgc_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [20:0]  out_sample,
  output logic                meter_valid,
  output logic [19:0]         block_peak,
  output logic [19:0]         block_rms
);
  import mgc_pkg::*;

  mgc_state_t              state;
  mgc_state_t              state_next;
  logic [STEP_W-1:0]       step;
  logic [SUM_W-1:0]        dvd;
  logic [CNT_W-1:0]        divisor;
  logic [CNT_W-1:0]        rem;
  logic [SQ_W-1:0]         rad;
  logic [MAG_W:0]          srem;
  logic [MAG_W-1:0]        root;
  logic [MAG_W-1:0]        peak_hold;
  logic signed [OUT_W-1:0] sample_hold;

  logic                    out_free;
  logic                    load_pass;
  logic                    load_meter;
  logic                    start;
  logic [CNT_W:0]          div_trial;
  logic [CNT_W:0]          div_diff;
  logic                    div_bit;
  logic [SUM_W-1:0]        dvd_next;
  logic [CNT_W-1:0]        rem_next;
  logic [MAG_W+2:0]        sq_trial;
  logic [MAG_W+2:0]        sq_rem_sh;
  logic [MAG_W+2:0]        sq_diff;
  logic                    sq_bit;

  assign out_free = !out_valid || out_ready;

  // Restoring divide, one quotient bit per cycle
  assign div_trial = {rem, dvd[SUM_W-1]};
  assign div_diff  = div_trial - {1'b0, divisor};
  assign div_bit   = div_trial >= {1'b0, divisor};
  assign rem_next  = div_bit ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
  assign dvd_next  = {dvd[SUM_W-2:0], div_bit};

  // Digit-by-digit square root, one result bit per cycle
  assign sq_rem_sh = {srem, rad[SQ_W-1:SQ_W-2]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_diff   = sq_rem_sh - sq_trial;
  assign sq_bit    = sq_rem_sh >= sq_trial;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!empty && head.closes) state_next = ST_DIV;
      ST_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_SQRT;
      ST_SQRT: if (step == STEP_W'(SQRT_STEPS - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    load_pass  = 1'b0;
    load_meter = 1'b0;
    start      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        start     = !empty && head.closes;
        load_pass = !empty && !head.closes && out_free;
      end
      ST_DONE: load_meter = out_free;
      default: begin
      end
    endcase
    pop = start || load_pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        step <= '0;
      end else if (state == ST_DIV || state == ST_SQRT) begin
        step <= step + STEP_W'(1);
      end
      if (out_free) begin
        out_valid <= load_pass || load_meter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd         <= head.sum;
      divisor     <= head.count;
      rem         <= '0;
      peak_hold   <= head.peak;
      sample_hold <= head.sample;
    end
    if (state == ST_DIV) begin
      dvd <= dvd_next;
      rem <= rem_next;
      // hand the quotient to the root on the last divide step
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        rad  <= dvd_next[SQ_W-1:0];
        srem <= '0;
        root <= '0;
      end
    end
    if (state == ST_SQRT) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      srem <= sq_bit ? sq_diff[MAG_W:0] : sq_rem_sh[MAG_W:0];
      root <= {root[MAG_W-2:0], sq_bit};
    end
    if (load_pass) begin
      out_sample  <= head.sample;
      meter_valid <= 1'b0;
      block_peak  <= '0;
      block_rms   <= '0;
    end else if (load_meter) begin
      out_sample  <= sample_hold;
      meter_valid <= 1'b1;
      block_peak  <= peak_hold;
      block_rms   <= root;
    end
  end

  assert property (@(posedge clk) disable iff (rst) state != ST_IDLE |-> !pop)
    else $error("queue popped while a block end is in work");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> block_rms <= ONE_Q19)
    else $error("rms out of range");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !meter_valid |-> block_peak == '0 && block_rms == '0)
    else $error("meters not zero outside block end");
  assert property (@(posedge clk) disable iff (rst) state == ST_DIV |-> divisor != '0)
    else $error("divide by zero count");

endmodule
